>>> design/sliding_window_extremum_detector_unit_defines.svh
// Assertion macros for the sliding-window extremum detector.
// Included by the top level; no other dependencies.
`ifndef SLIDING_WINDOW_EXTREMUM_DETECTOR_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_EXTREMUM_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define SWED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("swed: implication check failed");
// next-cycle implication, disabled during reset
`define SWED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("swed: next-cycle check failed");
`else
`define SWED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SWED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/swed_pkg.sv
// Shared types and constants of the sliding-window extremum detector.
// No dependencies; used by every module of the block.
`default_nettype none

package swed_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_MAX  = 2'd0,
		KIND_MIN  = 2'd1,
		KIND_FLAT = 2'd2
	} swed_kind_t;

	// configuration register indexes
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD   = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_TIME_OFFSET = 1'b1;

	localparam int DATA_W   = 32;
	localparam int THRESH_W = 31;

	// result queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic                 we;
		logic [REG_IDX_W-1:0] index;
		logic [DATA_W-1:0]    data;
	} swed_cfg_t;

	// value/extra: extremum -> sample, one-based center index
	//              flat     -> series minimum, series maximum
	typedef struct packed {
		swed_kind_t        kind;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] extra;
	} swed_entry_t;

	typedef struct packed {
		logic        push;
		swed_entry_t entry;
	} swed_push_t;

	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] count;
	} swed_qstat_t;

endpackage

`default_nettype wire

>>> design/swed_front.sv
// Front end: takes samples, keeps the window and series state, classifies
// the window center and pushes results into the queue. Uses swed_pkg.
`default_nettype none

module swed_front #(
	parameter int WINDOW = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swed_pkg::swed_cfg_t   cfg,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  logic signed [31:0]    sample,
	input  logic                  last,
	input  swed_pkg::swed_qstat_t qstat,
	output swed_pkg::swed_push_t  push,
	output logic                  busy
);
	import swed_pkg::*;

	localparam int CENTER = (WINDOW - 1) / 2;
	localparam logic [DATA_W-1:0] POS_ADJ = DATA_W'(2 - WINDOW + CENTER);
	localparam logic [DATA_W-1:0] WIN_U   = DATA_W'(WINDOW);

	logic [THRESH_W-1:0]      thresh_q;
	logic signed [DATA_W-1:0] window_q [WINDOW];
	logic [DATA_W-1:0]        count_q;
	logic                     full_q;
	logic                     fresh_q;
	logic signed [DATA_W-1:0] min_q;
	logic signed [DATA_W-1:0] max_q;

	logic                     valid_s1;
	logic                     last_s1;
	logic                     full_s1;
	logic [DATA_W-1:0]        pos_s1;

	logic                     accept;
	logic [DATA_W-1:0]        count_inc;
	logic                     full_new;
	logic signed [DATA_W-1:0] base_min;
	logic signed [DATA_W-1:0] base_max;

	// one slot is needed for the item in s1 and one for the new item
	assign sample_stall = ((QCNT_W+1)'(qstat.count) + (QCNT_W+1)'(valid_s1))
		>= (QCNT_W+1)'(QUEUE_DEPTH);
	assign accept    = sample_valid && !sample_stall;
	assign busy      = valid_s1;
	assign count_inc = count_q + 1'b1;
	assign full_new  = full_q || (count_inc >= WIN_U);
	assign base_min  = fresh_q ? 32'sh7FFF_FFFF : min_q;
	assign base_max  = fresh_q ? 32'sh8000_0000 : max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_W'(1);
			count_q  <= '0;
			full_q   <= 1'b0;
			fresh_q  <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg.we && cfg.index == REG_THRESHOLD) begin
				thresh_q <= cfg.data[THRESH_W-1:0];
			end
			valid_s1 <= accept;
			if (accept) begin
				count_q <= last ? '0 : count_inc;
				full_q  <= last ? 1'b0 : full_new;
				fresh_q <= last;
			end
		end
	end

	// window contents after end of series are don't-care: the count
	// restarts and every slot is refilled before the next evaluation
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				window_q[i] <= window_q[i+1];
			end
			window_q[WINDOW-1] <= sample;
			min_q   <= (sample < base_min) ? sample : base_min;
			max_q   <= (sample > base_max) ? sample : base_max;
			last_s1 <= last;
			full_s1 <= full_new;
			pos_s1  <= count_q + POS_ADJ;
		end
	end

	// s1: window_q and min/max still hold the state right after the item
	logic signed [DATA_W-1:0] ctr;
	logic signed [DATA_W:0]   thr_s;
	logic signed [DATA_W:0]   diff_hi;
	logic signed [DATA_W:0]   diff_lo;
	logic signed [DATA_W:0]   range;
	logic                     is_max;
	logic                     is_min;
	logic                     reach_hi;
	logic                     reach_lo;

	always_comb begin
		ctr      = window_q[CENTER];
		thr_s    = $signed({2'b00, thresh_q});
		is_max   = 1'b1;
		is_min   = 1'b1;
		reach_hi = 1'b0;
		reach_lo = 1'b0;
		diff_hi  = '0;
		diff_lo  = '0;
		for (int i = 1; i <= CENTER; i++) begin
			if (window_q[CENTER-i] >= ctr || window_q[CENTER+i] > ctr) is_max = 1'b0;
			if (window_q[CENTER-i] <= ctr || window_q[CENTER+i] < ctr) is_min = 1'b0;
		end
		// center minus window minimum reaches the threshold iff some
		// element lies at least threshold below the center
		for (int j = 0; j < WINDOW; j++) begin
			diff_hi = $signed({ctr[DATA_W-1], ctr})
				- $signed({window_q[j][DATA_W-1], window_q[j]});
			diff_lo = -diff_hi;
			if (diff_hi >= thr_s) reach_hi = 1'b1;
			if (diff_lo >= thr_s) reach_lo = 1'b1;
		end
		range = $signed({max_q[DATA_W-1], max_q}) - $signed({min_q[DATA_W-1], min_q});
	end

	always_comb begin
		push.push        = 1'b0;
		push.entry.kind  = KIND_MAX;
		push.entry.value = ctr;
		push.entry.extra = pos_s1;
		if (full_s1 && is_max && reach_hi) begin
			push.push = valid_s1;
		end else if (full_s1 && is_min && reach_lo) begin
			push.push       = valid_s1;
			push.entry.kind = KIND_MIN;
		end else if (last_s1 && range < thr_s) begin
			push.push        = valid_s1;
			push.entry.kind  = KIND_FLAT;
			push.entry.value = min_q;
			push.entry.extra = max_q;
		end
	end

endmodule

`default_nettype wire

>>> design/swed_queue.sv
// Short result queue that decouples the front end from the output stage.
// Uses swed_pkg for the entry type and depth.
`default_nettype none

module swed_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swed_pkg::swed_push_t  push,
	input  logic                  pop,
	output swed_pkg::swed_entry_t head,
	output swed_pkg::swed_qstat_t qstat
);
	import swed_pkg::*;

	swed_entry_t       entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head        = entries_q[rd_ptr_q];
	assign qstat.count = count_q;
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)       rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push.push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push.push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push.push) entries_q[wr_ptr_q] <= push.entry;
	end

endmodule

`default_nettype wire

>>> design/swed_back.sv
// Back end: drains the queue, forms position and flat midpoint, and holds
// the result in the output register. Uses swed_pkg.
`default_nettype none

module swed_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swed_pkg::swed_cfg_t   cfg,
	input  swed_pkg::swed_entry_t head,
	input  swed_pkg::swed_qstat_t qstat,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [1:0]            kind,
	output logic signed [31:0]    value,
	output logic [31:0]           position
);
	import swed_pkg::*;

	logic [DATA_W-1:0]        offset_q;
	logic                     valid_q;
	swed_kind_t               kind_q;
	logic [DATA_W-1:0]        value_q;
	logic [DATA_W-1:0]        position_q;
	logic signed [DATA_W:0]   mid_sum;

	assign pop = !qstat.empty && (!valid_q || !result_stall);
	// arithmetic shift of the 33-bit sum rounds toward minus infinity
	assign mid_sum = $signed({head.value[DATA_W-1], head.value})
		+ $signed({head.extra[DATA_W-1], head.extra});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (cfg.we && cfg.index == REG_TIME_OFFSET) offset_q <= cfg.data;
			if (pop)               valid_q <= 1'b1;
			else if (!result_stall) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head.kind;
			if (head.kind == KIND_FLAT) begin
				value_q    <= mid_sum[DATA_W:1];
				position_q <= '0;
			end else begin
				value_q    <= head.value;
				position_q <= head.extra + offset_q;
			end
		end
	end

	assign result_valid = valid_q;
	assign kind         = kind_q;
	assign value        = value_q;
	assign position     = position_q;

endmodule

`default_nettype wire

>>> design/sliding_window_extremum_detector_unit.sv
// Sliding-window extremum detector, top level.
// Instantiates swed_front, swed_queue and swed_back; uses swed_pkg.
//
// Usage:
//   Samples (signed Q16.16) enter on sample/last with sample_valid and
//   sample_stall; a transfer happens when valid is high and stall is low.
//   Once WINDOW samples of a series are in, every sample completes a window
//   and the center is checked for a significant local maximum or minimum.
//   The sample flagged last may instead report the midpoint of a flat series.
//   At most one result per sample leaves on kind/value/position with
//   result_valid and result_stall.
//   Throughput: one sample per cycle while sample_stall is low, set by the
//   combinational window compare in the front end; results drain one per
//   cycle from the output register while result_stall is low.
//   The four-entry result queue absorbs receiver stalls; sample_stall rises
//   only when the queue plus the item under evaluation could fill it.
//   Configuration (cfg_we/cfg_index/cfg_data) is written while idle:
//   index 0 threshold (31 bits), index 1 time offset.
//   Reset (arst_n low) empties the queue, drops any held result, starts a
//   new series and loads threshold 1 and time offset 0.
`default_nettype none
`include "sliding_window_extremum_detector_unit_defines.svh"

module sliding_window_extremum_detector_unit #(
	parameter int WINDOW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic signed [31:0]   sample,
	input  logic                 last,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [1:0]           kind,
	output logic signed [31:0]   value,
	output logic [31:0]          position
);
	import swed_pkg::*;

	swed_cfg_t   cfg;
	swed_push_t  push;
	swed_entry_t head;
	swed_qstat_t qstat;
	logic        pop;
	logic        front_busy;

	// one config bundle feeds both halves; each picks its own register
	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// front: window shift, series min/max, center classification
	swed_front #(
		.WINDOW(WINDOW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.last         (last),
		.qstat        (qstat),
		.push         (push),
		.busy         (front_busy)
	);

	// decoupling queue
	swed_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// back: position offset, flat midpoint, output register
	swed_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.value        (value),
		.position     (position)
	);

	// the stall margin must keep the queue from overflowing
	`SWED_ASSERT_IMPL(a_no_overflow, clk, arst_n, push.push && !pop, qstat.count != QCNT_W'(QUEUE_DEPTH))
	// the output stage only drains a non-empty queue
	`SWED_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, !qstat.empty)
	// every transferred sample is evaluated in the following cycle
	`SWED_ASSERT_NEXT(a_eval_follows, clk, arst_n, sample_valid && !sample_stall, front_busy)
	// flat reports carry no position
	`SWED_ASSERT_IMPL(a_flat_pos, clk, arst_n, result_valid && kind == KIND_FLAT, position == '0)

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench of the sliding-window extremum detector: sends
// sample series, predicts every report with a local model and checks them.
// Depends on swed_pkg and sliding_window_extremum_detector_unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import swed_pkg::*;

	localparam int WIN            = 7;
	localparam int CTR            = (WIN - 1) / 2;
	localparam int WATCHDOG_LIMIT = 2000;	// quiet cycles before giving up
	localparam int DRAIN_CYCLES   = 6;	// covers the result latency
	localparam int LONG_HOLD      = 150;	// receiver hold-off under pressure
	localparam int PHASE_SAMPLES  = 130;
	localparam int MAX_REPORTS    = 50;	// mismatch lines printed at most

	typedef struct {
		logic signed [31:0] sample;
		logic               last;
	} sample_item_t;

	typedef struct {
		swed_kind_t         kind;
		logic signed [31:0] value;
		logic [31:0]        position;
	} extremum_t;

	// DUT ports; every input is known from time zero
	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index    = REG_THRESHOLD;
	logic [31:0]          cfg_data     = '0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	logic signed [31:0]   sample       = '0;
	logic                 last         = 1'b0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [1:0]           kind;
	logic signed [31:0]   value;
	logic [31:0]          position;

	// model of the detector: window, series statistics, register copies
	logic signed [31:0] trail [WIN];
	logic [31:0]        seen;
	bit                 primed;
	logic signed [31:0] series_lo, series_hi;
	logic [30:0]        thresh_q = 31'd1;
	logic [31:0]        offset_q = '0;

	sample_item_t sample_queue[$];		// samples waiting for the driver
	extremum_t    predicted[$];		// reports not yet seen on the output

	bit sample_handed;	// set at the edge that takes the presented sample
	bit no_idle;		// both sides run without gaps
	bit hold_request;	// asks the receiver for one long hold-off
	int send_wait, stall_left, quiet_cycles;
	int fault_count, samples_sent, series_sent, reports_seen, settings_used;
	int kind_tally [3];

	sliding_window_extremum_detector_unit #(.WINDOW(WIN)) dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.sample_valid, .sample_stall, .sample, .last,
		.result_valid, .result_stall, .kind, .value, .position
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------
	function automatic void reset_series();
		foreach (trail[i]) trail[i] = '0;
		seen      = '0;
		primed    = 1'b0;
		series_lo = 32'sh7FFFFFFF;
		series_hi = 32'sh80000000;
	endfunction

	// Shifts one sample into the window and returns 1 with the report it
	// causes, if any. A flat report is only possible on the last sample and
	// only when the final window gave no extremum.
	function automatic bit detect_extremum(input logic signed [31:0] s, input logic l,
		output extremum_t rep);
		logic [31:0]        idx;
		logic signed [31:0] c, wmin, wmax, lft, rgt;
		bit                 is_max, is_min, found;
		longint             sum;
		idx = seen;
		found = 1'b0;
		rep.kind = KIND_MAX;
		rep.value = '0;
		rep.position = '0;
		for (int i = 0; i < WIN - 1; i++) trail[i] = trail[i + 1];
		trail[WIN - 1] = s;
		if (s < series_lo) series_lo = s;
		if (s > series_hi) series_hi = s;
		if (idx + 32'd1 >= WIN) primed = 1'b1;	// stays set if the count wraps
		seen = idx + 32'd1;
		if (primed) begin
			c = trail[CTR];
			wmin = trail[0];
			wmax = trail[0];
			for (int i = 1; i < WIN; i++) begin
				if (trail[i] < wmin) wmin = trail[i];
				if (trail[i] > wmax) wmax = trail[i];
			end
			is_max = 1'b1;
			is_min = 1'b1;
			// left side strict, right side may tie
			for (int i = 1; i <= CTR; i++) begin
				lft = trail[CTR - i];
				rgt = trail[CTR + i];
				if (lft >= c || rgt > c) is_max = 1'b0;
				if (lft <= c || rgt < c) is_min = 1'b0;
			end
			rep.value = c;
			rep.position = idx + 32'(2 - WIN + CTR) + offset_q;
			if (is_max && longint'(c) - longint'(wmin) >= longint'(thresh_q)) begin
				rep.kind = KIND_MAX;
				found = 1'b1;
			end else if (is_min && longint'(wmax) - longint'(c) >= longint'(thresh_q)) begin
				rep.kind = KIND_MIN;
				found = 1'b1;
			end
		end
		if (l) begin
			if (!found && longint'(series_hi) - longint'(series_lo) < longint'(thresh_q)) begin
				sum = longint'(series_lo) + longint'(series_hi);
				rep.kind = KIND_FLAT;
				rep.value = 32'(sum >>> 1);	// floor of the midpoint
				rep.position = '0;
				found = 1'b1;
			end
			reset_series();
		end
		return found;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int gap_length();
		int r;
		r = $urandom_range(99);
		if (no_idle || r < 60) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// ------------------------------------------------------------------
	// Sample driver: changes its outputs at the falling edge only
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		sample_item_t it;
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!sample_valid || sample_handed) begin
			sample_handed = 1'b0;
			if (send_wait > 0) begin
				send_wait--;
				sample_valid <= 1'b0;
			end else if (sample_queue.size() != 0) begin
				it = sample_queue.pop_front();
				sample_valid <= 1'b1;
				sample <= it.sample;
				last <= it.last;
				send_wait = gap_length();
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: random stalls, plus one long hold-off on request
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !no_idle && $urandom_range(99) < 50) begin
				stall_left = gap_length();
			end
			result_stall <= (stall_left > 0);
			if (stall_left > 0) stall_left--;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on each sample transfer, checks each result transfer
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		extremum_t due;
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				sample_handed = 1'b1;
				samples_sent++;
				if (last) series_sent++;
				if (detect_extremum(sample, last, due)) predicted.push_back(due);
			end
			if (result_valid && !result_stall) begin
				reports_seen++;
				if (predicted.size() == 0) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("%0t: result with none expected: kind %0d value %0d position %0d",
							$time, kind, value, position);
				end else begin
					due = predicted.pop_front();
					kind_tally[due.kind]++;
					if (kind !== due.kind || value !== due.value || position !== due.position) begin
						fault_count++;
						if (fault_count <= MAX_REPORTS) begin
							if (kind !== due.kind)
								$display("%0t: kind expected %0d actual %0d",
									$time, due.kind, kind);
							if (value !== due.value)
								$display("%0t: value expected %0d actual %0d",
									$time, due.value, value);
							if (position !== due.position)
								$display("%0t: position expected %0d actual %0d",
									$time, due.position, position);
						end
					end
				end
			end
		end
	end

	// Watchdog: any transfer or register write proves progress
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall) || cfg_we) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, predicted.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_THRESHOLD) thresh_q = data[30:0];
		else offset_q = data;
		settings_used++;
	endtask

	task automatic add_sample(input logic signed [31:0] s, input logic l);
		sample_item_t it;
		it.sample = s;
		it.last = l;
		sample_queue.push_back(it);
	endtask

	// Waits until every sample is taken and every report has come out, then
	// lets the pipeline drain, since the last samples may cause no report.
	task automatic settle();
		do @(posedge clk);
		while (sample_queue.size() != 0 || sample_valid || predicted.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Whole series of random length and shape until the budget is used up.
	// Short series end before the window fills; waves give many extrema.
	task automatic queue_random_series(input int budget);
		int                 made, len, shape, amp, slope;
		logic signed [31:0] level, s;
		made = 0;
		while (made < budget) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(20, 1);
			shape = $urandom_range(5);
			amp = 1 << $urandom_range(30);
			level = $urandom;
			for (int k = 0; k < len; k++) begin
				case (shape)
					0: s = $urandom;
					1: begin
						level = level + int'($urandom_range(amp)) - amp / 2;
						s = level;
					end
					2: begin
						if ($urandom_range(5) == 0) s = $urandom_range(1) ? level + amp : level - amp;
						else s = level;
					end
					3: begin
						case ($urandom_range(5))
							0: s = 32'sh80000000;
							1: s = 32'sh7FFFFFFF;
							2: s = 32'sh80000001;
							3: s = -32'sd1;
							4: s = 32'sd1;
							default: s = '0;
						endcase
					end
					4: s = level + int'($urandom_range(3));
					default: begin
						slope = k % 8;
						s = level + ((slope < 4) ? slope : 8 - slope) * (amp >>> 2);
					end
				endcase
				add_sample(s, k == len - 1);
			end
			made += len;
		end
	endtask

	initial begin
		logic [31:0] thr_set [4];
		logic [31:0] off_set [4];
		reset_series();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_THRESHOLD, 32'd1);
		write_reg(REG_TIME_OFFSET, 32'd0);

		// directed: extreme values as one-sample flat series, a full-scale
		// pair, a peak with a tied right neighbor and a valley, each ending
		// on its last window
		add_sample(32'sh80000000, 1'b1);
		add_sample(32'sh7FFFFFFF, 1'b1);
		add_sample(-32'sd1, 1'b1);
		add_sample(32'sh80000000, 1'b0);
		add_sample(32'sh7FFFFFFF, 1'b1);
		add_sample(32'sd0, 1'b0); add_sample(32'sd0, 1'b0); add_sample(32'sd0, 1'b0);
		add_sample(32'sd100, 1'b0); add_sample(32'sd100, 1'b0); add_sample(32'sd0, 1'b0);
		add_sample(32'sd0, 1'b1);
		add_sample(32'sd5, 1'b0); add_sample(32'sd5, 1'b0); add_sample(32'sd5, 1'b0);
		add_sample(-32'sd7, 1'b0); add_sample(32'sd5, 1'b0); add_sample(32'sd5, 1'b0);
		add_sample(32'sd5, 1'b1);
		settle();

		// pressure: every one-sample series reports flat; the receiver holds
		// off while samples keep coming, so the result queue fills up
		no_idle = 1'b1;
		hold_request = 1'b1;
		for (int k = 0; k < 40; k++) add_sample($urandom, 1'b1);
		settle();
		no_idle = 1'b0;

		// random phases: zero threshold with wrapping positions, full-scale
		// threshold and offset, a small threshold without gaps, then random
		thr_set = '{32'd0, 32'h7FFFFFFF, 32'd1 << $urandom_range(20), $urandom};
		off_set = '{32'hFFFFFFFC, 32'hFFFFFFFF, $urandom, 32'd0};
		for (int p = 0; p < 4; p++) begin
			write_reg(REG_THRESHOLD, thr_set[p]);
			write_reg(REG_TIME_OFFSET, off_set[p]);
			no_idle = (p == 2);
			queue_random_series(PHASE_SAMPLES);
			settle();
			no_idle = 1'b0;
		end

		$display("Sent %0d samples in %0d series; checked %0d results: %0d maxima, %0d minima, %0d flat",
			samples_sent, series_sent, reports_seen, kind_tally[KIND_MAX], kind_tally[KIND_MIN],
			kind_tally[KIND_FLAT]);
		$display("Register writes: %0d, thresholds from zero to full scale, %0d mismatches",
			settings_used, fault_count);
		if (fault_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
